### hw/rtl/tqwps_pkg.sv
// Package for the two-queue weighted priority server: codes, types and defaults.
package tqwps_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;
    localparam int unsigned TAG_WIDTH_DEF   = 16;

    localparam int unsigned LIMIT_WIDTH = 4;
    localparam int unsigned CMD_WIDTH   = 2;
    localparam int unsigned STAT_WIDTH  = 2;

    localparam logic [LIMIT_WIDTH-1:0] BURST_RESET = 4'd3;
    localparam logic [LIMIT_WIDTH-1:0] RUN_MAX     = 4'd15;

    // command codes; code 3 decodes as serve
    localparam logic [CMD_WIDTH-1:0] CMD_ENQ_NORMAL   = 2'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_ENQ_PRIORITY = 2'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_SERVE        = 2'd2;
    localparam logic [CMD_WIDTH-1:0] CMD_SERVE_ALT    = 2'd3;

    localparam logic [STAT_WIDTH-1:0] STAT_ENQUEUED = 2'd0;
    localparam logic [STAT_WIDTH-1:0] STAT_DROPPED  = 2'd1;
    localparam logic [STAT_WIDTH-1:0] STAT_SERVED   = 2'd2;
    localparam logic [STAT_WIDTH-1:0] STAT_EMPTY    = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

endpackage

### hw/rtl/tqwps_ram.sv
// Generic single-port synchronous RAM with registered read.
module tqwps_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### hw/rtl/tqwps_ctrl.sv
// Queue pointers, arbitration, memory addressing and the result register.
module tqwps_ctrl #(
    parameter int unsigned QUEUE_DEPTH = tqwps_pkg::QUEUE_DEPTH_DEF,
    parameter int unsigned TAG_WIDTH   = tqwps_pkg::TAG_WIDTH_DEF,
    localparam int unsigned AW = $clog2(QUEUE_DEPTH),
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [tqwps_pkg::LIMIT_WIDTH-1:0] cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [TAG_WIDTH-1:0]             s_tag,
    input  logic [tqwps_pkg::CMD_WIDTH-1:0]  s_cmd,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [TAG_WIDTH-1:0]             m_tag,
    output logic [tqwps_pkg::STAT_WIDTH-1:0] m_status,
    output logic                             m_from_pri,
    output logic                             pri_we,
    output logic [AW-1:0]                    pri_addr,
    input  logic [TAG_WIDTH-1:0]             pri_rdata,
    output logic                             nrm_we,
    output logic [AW-1:0]                    nrm_addr,
    input  logic [TAG_WIDTH-1:0]             nrm_rdata
);

    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
    localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

    tqwps_pkg::state_t state_reg, state_next;

    logic [AW-1:0] pri_head_reg, nrm_head_reg;
    logic [CW-1:0] pri_cnt_reg, nrm_cnt_reg;
    logic [tqwps_pkg::LIMIT_WIDTH-1:0] run_reg, limit_reg;
    logic          src_pri_reg;

    logic                             out_valid_reg;
    logic [TAG_WIDTH-1:0]             out_tag_reg;
    logic [tqwps_pkg::STAT_WIDTH-1:0] out_status_reg;
    logic                             out_pri_reg;

    logic accept, serve, pri_ne, nrm_ne, take_pri, take_nrm;
    logic pri_full, nrm_full, enq_pri, enq_nrm;
    logic [AW-1:0] pri_tail, nrm_tail, pri_head_inc, nrm_head_inc;
    logic [AW:0]   pri_sum, nrm_sum;

    assign serve    = s_cmd inside {tqwps_pkg::CMD_SERVE, tqwps_pkg::CMD_SERVE_ALT};
    assign pri_ne   = pri_cnt_reg != '0;
    assign nrm_ne   = nrm_cnt_reg != '0;
    assign pri_full = pri_cnt_reg == FULL_CNT;
    assign nrm_full = nrm_cnt_reg == FULL_CNT;
    // burst not used up takes priority first; empty normal queue falls back to priority
    assign take_pri = serve && pri_ne && ((run_reg < limit_reg) || !nrm_ne);
    assign take_nrm = serve && !take_pri && nrm_ne;
    assign enq_pri  = !serve && (s_cmd == tqwps_pkg::CMD_ENQ_PRIORITY) && !pri_full;
    assign enq_nrm  = !serve && (s_cmd == tqwps_pkg::CMD_ENQ_NORMAL) && !nrm_full;

    // tail = (head + count) mod depth, sum stays below twice the depth
    assign pri_sum  = (AW + 1)'(pri_head_reg) + (AW + 1)'(pri_cnt_reg);
    assign nrm_sum  = (AW + 1)'(nrm_head_reg) + (AW + 1)'(nrm_cnt_reg);
    assign pri_tail = (pri_sum >= DEPTH_W) ? AW'(pri_sum - DEPTH_W) : AW'(pri_sum);
    assign nrm_tail = (nrm_sum >= DEPTH_W) ? AW'(nrm_sum - DEPTH_W) : AW'(nrm_sum);
    assign pri_head_inc = (pri_head_reg == LAST_IDX) ? '0 : pri_head_reg + 1'b1;
    assign nrm_head_inc = (nrm_head_reg == LAST_IDX) ? '0 : nrm_head_reg + 1'b1;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tqwps_pkg::ST_IDLE: begin
                if (accept && (take_pri || take_nrm)) begin
                    state_next = tqwps_pkg::ST_READ;
                end
            end
            tqwps_pkg::ST_READ: state_next = tqwps_pkg::ST_IDLE;
            default:            state_next = tqwps_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = 1'b0;
        case (state_reg)
            tqwps_pkg::ST_IDLE: s_tready = !out_valid_reg || m_tready;
            tqwps_pkg::ST_READ: s_tready = 1'b0;
            default:            s_tready = 1'b0;
        endcase
        accept   = s_tvalid && s_tready;
        pri_we   = accept && enq_pri;
        nrm_we   = accept && enq_nrm;
        pri_addr = serve ? pri_head_reg : pri_tail;
        nrm_addr = serve ? nrm_head_reg : nrm_tail;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tqwps_pkg::ST_IDLE;
            pri_head_reg  <= '0;
            nrm_head_reg  <= '0;
            pri_cnt_reg   <= '0;
            nrm_cnt_reg   <= '0;
            run_reg       <= '0;
            limit_reg     <= tqwps_pkg::BURST_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            // result is ready at once unless a tag has to be read first
            if (accept && !(take_pri || take_nrm)) begin
                out_valid_reg <= 1'b1;
            end else if (state_reg == tqwps_pkg::ST_READ) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (accept) begin
                if (enq_pri) begin
                    pri_cnt_reg <= pri_cnt_reg + 1'b1;
                end
                if (enq_nrm) begin
                    nrm_cnt_reg <= nrm_cnt_reg + 1'b1;
                end
                if (take_pri) begin
                    pri_head_reg <= pri_head_inc;
                    pri_cnt_reg  <= pri_cnt_reg - 1'b1;
                    if (run_reg != tqwps_pkg::RUN_MAX) begin
                        run_reg <= run_reg + 1'b1;
                    end
                end
                if (take_nrm) begin
                    nrm_head_reg <= nrm_head_inc;
                    nrm_cnt_reg  <= nrm_cnt_reg - 1'b1;
                    run_reg      <= '0;
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            src_pri_reg <= take_pri;
            out_tag_reg <= '0;
            out_pri_reg <= 1'b0;
            if (serve) begin
                out_status_reg <= tqwps_pkg::STAT_EMPTY;
            end else if (enq_pri || enq_nrm) begin
                out_status_reg <= tqwps_pkg::STAT_ENQUEUED;
            end else begin
                out_status_reg <= tqwps_pkg::STAT_DROPPED;
            end
        end
        if (state_reg == tqwps_pkg::ST_READ) begin
            out_tag_reg    <= src_pri_reg ? pri_rdata : nrm_rdata;
            out_pri_reg    <= src_pri_reg;
            out_status_reg <= tqwps_pkg::STAT_SERVED;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tag      = out_tag_reg;
    assign m_status   = out_status_reg;
    assign m_from_pri = out_pri_reg;

endmodule

### hw/rtl/two_queue_weighted_priority_server_unit.sv
// Two-queue weighted priority server: top level with the two tag memories.
//
// Each transfer on the s_ side is one command and yields exactly one transfer on
// the m_ side. Enqueue commands write the tag at the queue tail and register the
// status (enqueued or dropped when full) at once. A serve that finds an item must
// wait for the registered read of the tag memories: the head is read at
// acceptance and the served tag is registered in the following cycle. A serve with
// both queues empty registers its status at once, like an enqueue.
// A new command is taken once the result register is empty or being drained and
// no tag read is in progress; with m_tready high that is one enqueue per cycle.
// The burst limit may be written through cfg_wr_en/cfg_wr_data while the block is
// idle. The memories need no clearing: only occupied entries are ever returned.
module two_queue_weighted_priority_server_unit #(
    parameter int unsigned QUEUE_DEPTH = tqwps_pkg::QUEUE_DEPTH_DEF,
    parameter int unsigned TAG_WIDTH   = tqwps_pkg::TAG_WIDTH_DEF,
    localparam int unsigned DATA_WIDTH = ((TAG_WIDTH + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tqwps_pkg::LIMIT_WIDTH-1:0] cfg_wr_data, // burst_limit
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [DATA_WIDTH-1:0]             s_tdata,     // item_tag
    input  logic [tqwps_pkg::CMD_WIDTH-1:0]   s_tuser,     // command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [DATA_WIDTH-1:0]             m_tdata,     // served_tag
    output logic [2:0]                        m_tuser      // status, served_from_priority
);

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);

    logic                             pri_we, nrm_we;
    logic [AW-1:0]                    pri_addr, nrm_addr;
    logic [TAG_WIDTH-1:0]             pri_rdata, nrm_rdata, m_tag;
    logic [tqwps_pkg::STAT_WIDTH-1:0] m_status;
    logic                             m_from_pri;

    tqwps_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_WIDTH   (TAG_WIDTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tag       (s_tdata[TAG_WIDTH-1:0]),
        .s_cmd       (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tag       (m_tag),
        .m_status    (m_status),
        .m_from_pri  (m_from_pri),
        .pri_we      (pri_we),
        .pri_addr    (pri_addr),
        .pri_rdata   (pri_rdata),
        .nrm_we      (nrm_we),
        .nrm_addr    (nrm_addr),
        .nrm_rdata   (nrm_rdata)
    );

    tqwps_ram #(
        .WIDTH (TAG_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_pri_ram (
        .aclk  (aclk),
        .we    (pri_we),
        .addr  (pri_addr),
        .wdata (s_tdata[TAG_WIDTH-1:0]),
        .rdata (pri_rdata)
    );

    tqwps_ram #(
        .WIDTH (TAG_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_nrm_ram (
        .aclk  (aclk),
        .we    (nrm_we),
        .addr  (nrm_addr),
        .wdata (s_tdata[TAG_WIDTH-1:0]),
        .rdata (nrm_rdata)
    );

    assign m_tdata = DATA_WIDTH'(m_tag);
    assign m_tuser = {m_from_pri, m_status};

endmodule

### verif/two_queue_weighted_priority_server_unit_tb.sv
// Testbench for the two-queue weighted priority server: directed table, random traffic.
`timescale 1ns / 100ps

module two_queue_weighted_priority_server_unit_tb;

    localparam int QDEPTH      = 16;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 90;
    localparam int PHASE_ITEMS = 190;

    typedef struct packed {
        logic [tqwps_pkg::STAT_WIDTH-1:0] status;
        logic [15:0]                      tag;
        logic                             pri;
    } outcome_t;

    typedef struct packed {
        logic [tqwps_pkg::CMD_WIDTH-1:0]  cmd;
        logic [15:0]                      tag;
        logic [4:0]                       reps;
        logic                             typed;
        logic [tqwps_pkg::STAT_WIDTH-1:0] status;
    } dir_row_t;

    logic                              aclk        = 1'b0;
    logic                              aresetn     = 1'b0;
    logic                              cfg_wr_en   = 1'b0;
    logic [tqwps_pkg::LIMIT_WIDTH-1:0] cfg_wr_data = '0;
    logic                              s_tvalid    = 1'b0;
    logic                              s_tready;
    logic [15:0]                       s_tdata     = '0;
    logic [tqwps_pkg::CMD_WIDTH-1:0]   s_tuser     = '0;
    logic                              m_tvalid;
    logic                              m_tready    = 1'b0;
    logic [15:0]                       m_tdata;
    logic [2:0]                        m_tuser;

    // predictor state
    logic [15:0]                       pri_slot [QDEPTH];
    logic [15:0]                       nrm_slot [QDEPTH];
    int                                pri_head, pri_cnt, nrm_head, nrm_cnt;
    logic [tqwps_pkg::LIMIT_WIDTH-1:0] pri_run;
    logic [tqwps_pkg::LIMIT_WIDTH-1:0] burst_limit;

    outcome_t awaited_outcomes[$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       src_idle_pct   = 0;
    int       sink_idle_pct  = 0;
    int       hold_left      = 0;
    logic     stall_req      = 1'b0;  // toggled by the stimulus to ask for a hold-off
    logic     stall_seen     = 1'b0;

    dir_row_t dir_table [8];

    two_queue_weighted_priority_server_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic outcome_t next_outcome(logic [tqwps_pkg::CMD_WIDTH-1:0] cmd,
                                              logic [15:0] tag);
        outcome_t o;
        o = '0;
        if (!cmd[1]) begin
            if (cmd[0]) begin
                if (pri_cnt >= QDEPTH) begin
                    o.status = tqwps_pkg::STAT_DROPPED;
                end else begin
                    pri_slot[(pri_head + pri_cnt) % QDEPTH] = tag;
                    pri_cnt++;
                    o.status = tqwps_pkg::STAT_ENQUEUED;
                end
            end else begin
                if (nrm_cnt >= QDEPTH) begin
                    o.status = tqwps_pkg::STAT_DROPPED;
                end else begin
                    nrm_slot[(nrm_head + nrm_cnt) % QDEPTH] = tag;
                    nrm_cnt++;
                    o.status = tqwps_pkg::STAT_ENQUEUED;
                end
            end
        end else if (pri_cnt != 0 && (pri_run < burst_limit || nrm_cnt == 0)) begin
            o.tag    = pri_slot[pri_head];
            o.pri    = 1'b1;
            o.status = tqwps_pkg::STAT_SERVED;
            pri_head = (pri_head + 1) % QDEPTH;
            pri_cnt--;
        end else if (nrm_cnt != 0) begin
            o.tag    = nrm_slot[nrm_head];
            o.status = tqwps_pkg::STAT_SERVED;
            nrm_head = (nrm_head + 1) % QDEPTH;
            nrm_cnt--;
            pri_run  = '0;
        end else begin
            o.status = tqwps_pkg::STAT_EMPTY;
        end
        // run count saturates
        if (o.pri && pri_run < tqwps_pkg::RUN_MAX)
            pri_run = pri_run + 1'b1;
        return o;
    endfunction

    // one command on the input stream; called and returning at a falling edge
    task automatic send_command(input logic [tqwps_pkg::CMD_WIDTH-1:0] cmd,
                                input logic [15:0] tag, input logic typed,
                                input logic [tqwps_pkg::STAT_WIDTH-1:0] typed_status);
        outcome_t o;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= tag;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        o = next_outcome(cmd, tag);
        if (typed)
            o = {typed_status, 16'h0000, 1'b0};
        awaited_outcomes.push_back(o);
        @(negedge aclk);
    endtask

    task automatic drain;
        while (awaited_outcomes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_burst_limit(input logic [tqwps_pkg::LIMIT_WIDTH-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        burst_limit = value;
    endtask

    function automatic logic [tqwps_pkg::CMD_WIDTH-1:0] pick_serve;
        return $urandom_range(0, 1) ? tqwps_pkg::CMD_SERVE : tqwps_pkg::CMD_SERVE_ALT;
    endfunction

    function automatic logic [tqwps_pkg::CMD_WIDTH-1:0] pick_enqueue(int r);
        return r[0] ? tqwps_pkg::CMD_ENQ_PRIORITY : tqwps_pkg::CMD_ENQ_NORMAL;
    endfunction

    // receiver: random idling plus one long hold-off on request
    always @(negedge aclk) begin
        if (stall_req != stall_seen) begin
            hold_left  = HOLD_CYCLES;
            stall_seen = stall_req;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // scoreboard
    always @(posedge aclk) begin
        outcome_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser[1:0], m_tdata, m_tuser[2]};
            if (awaited_outcomes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status %0d tag %h pri %0b",
                             got.status, got.tag, got.pri);
            end else begin
                want = awaited_outcomes.pop_front();
                if (got.status !== want.status || got.tag !== want.tag
                    || got.pri !== want.pri) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected status %0d tag %h pri %0b, ",
                                  "got status %0d tag %h pri %0b"},
                                 want.status, want.tag, want.pri,
                                 got.status, got.tag, got.pri);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [tqwps_pkg::CMD_WIDTH-1:0]   cmd;
        logic [15:0]                       tag;
        logic [tqwps_pkg::LIMIT_WIDTH-1:0] phase_limit [6];
        int                                mix, mix_left, r;

        pri_head = 0; pri_cnt = 0; nrm_head = 0; nrm_cnt = 0;
        pri_run = '0;
        burst_limit = tqwps_pkg::BURST_RESET;

        dir_table = '{
            '{tqwps_pkg::CMD_SERVE,        16'h0000, 5'd1,  1'b1, tqwps_pkg::STAT_EMPTY},
            '{tqwps_pkg::CMD_SERVE_ALT,    16'hFFFF, 5'd1,  1'b1, tqwps_pkg::STAT_EMPTY},
            '{tqwps_pkg::CMD_ENQ_PRIORITY, 16'hFFF0, 5'd16, 1'b1, tqwps_pkg::STAT_ENQUEUED},
            '{tqwps_pkg::CMD_ENQ_PRIORITY, 16'h1234, 5'd1,  1'b1, tqwps_pkg::STAT_DROPPED},
            '{tqwps_pkg::CMD_ENQ_NORMAL,   16'h0000, 5'd1,  1'b1, tqwps_pkg::STAT_ENQUEUED},
            '{tqwps_pkg::CMD_ENQ_NORMAL,   16'hFFFF, 5'd1,  1'b1, tqwps_pkg::STAT_ENQUEUED},
            '{tqwps_pkg::CMD_SERVE,        16'h5A5A, 5'd4,  1'b0, tqwps_pkg::STAT_SERVED},
            '{tqwps_pkg::CMD_SERVE_ALT,    16'hABCD, 5'd2,  1'b0, tqwps_pkg::STAT_SERVED}
        };

        src_idle_pct  = 21;
        sink_idle_pct = 81;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part at the reset burst limit; tag steps across a repeated row
        foreach (dir_table[i]) begin
            for (int k = 0; k < dir_table[i].reps; k++)
                send_command(dir_table[i].cmd, dir_table[i].tag + 16'(k),
                             dir_table[i].typed, dir_table[i].status);
        end
        s_tvalid <= 1'b0;

        phase_limit = '{4'd15, 4'd1, 4'd0, 4'($urandom_range(2, 14)), 4'd15,
                        4'($urandom_range(0, 15))};
        mix_left = 0;
        mix      = 0;

        for (int p = 0; p < 6; p++) begin
            drain();
            src_idle_pct  = (p < 2) ? 21 : (p < 4) ? 81 : 0;
            sink_idle_pct = (p < 2) ? 81 : (p < 4) ? 21 : 0;
            write_burst_limit(phase_limit[p]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 4 && i == 40)
                    stall_req <= ~stall_req;
                if (mix_left == 0) begin
                    mix      = $urandom_range(0, 4);
                    mix_left = $urandom_range(4, 24);
                end
                mix_left--;
                r = $urandom_range(0, 99);
                case (mix)
                    1: begin
                        cmd = (r < 70) ? tqwps_pkg::CMD_ENQ_PRIORITY :
                              (r < 85) ? tqwps_pkg::CMD_ENQ_NORMAL : pick_serve();
                    end
                    2: begin
                        cmd = (r < 70) ? tqwps_pkg::CMD_ENQ_NORMAL :
                              (r < 85) ? tqwps_pkg::CMD_ENQ_PRIORITY : pick_serve();
                    end
                    3: begin
                        cmd = (r < 75) ? pick_serve() : pick_enqueue(r);
                    end
                    4: begin
                        // priority traffic only: drives the run count to saturation
                        cmd = (r < 50) ? tqwps_pkg::CMD_ENQ_PRIORITY : pick_serve();
                    end
                    default: begin
                        cmd = 2'($urandom_range(0, 3));
                    end
                endcase
                r = $urandom_range(0, 7);
                tag = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF :
                      16'($urandom_range(0, 65535));
                send_command(cmd, tag, 1'b0, tqwps_pkg::STAT_ENQUEUED);
            end
            s_tvalid <= 1'b0;
        end

        while (awaited_outcomes.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
